/* src/ipff_pkg.sv */
package ipff_pkg;

  // ethertypes
  localparam logic [15:0] ETYPE_IPV4 = 16'h0800;
  localparam logic [15:0] ETYPE_ARP  = 16'h0806;
  localparam logic [15:0] ETYPE_RARP = 16'h8035;

  // ip protocol numbers
  localparam logic [7:0] PROTO_ICMP = 8'd1;
  localparam logic [7:0] PROTO_TCP  = 8'd6;
  localparam logic [7:0] PROTO_UDP  = 8'd17;

  // verdict codes
  localparam logic VERDICT_PASS = 1'b0;
  localparam logic VERDICT_DROP = 1'b1;

  // byte position saturates here
  localparam logic [5:0] POS_LIMIT = 6'd54;

  // minimum frame lengths per header
  localparam logic [5:0] LEN_ETH_HDR = 6'd14;
  localparam logic [5:0] LEN_IP_HDR  = 6'd34;
  localparam logic [5:0] LEN_UDP_HDR = 6'd42;
  localparam logic [5:0] LEN_TCP_HDR = 6'd54;

  // configuration register indexes
  localparam logic [2:0] CFG_SRC_ADDR  = 3'd0;
  localparam logic [2:0] CFG_DST_ADDR  = 3'd1;
  localparam logic [2:0] CFG_PROTO     = 3'd2;
  localparam logic [2:0] CFG_SRC_PORT  = 3'd3;
  localparam logic [2:0] CFG_DST_PORT  = 3'd4;

  // reason attached to each verdict
  typedef enum logic [2:0] {
    CAUSE_NON_IP   = 3'd0,
    CAUSE_SHORT    = 3'd1,
    CAUSE_MISMATCH = 3'd2,
    CAUSE_UNSUP    = 3'd3,
    CAUSE_MATCH    = 3'd4,
    CAUSE_PROTO    = 3'd5
  } cause_t;

endpackage

/* src/ipff_if.sv */
// frame byte channel
interface ipff_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] frame_byte;
  logic       frame_last;

  modport source (output valid, output frame_byte, output frame_last, input ready);
  modport sink   (input valid, input frame_byte, input frame_last, output ready);
endinterface

// verdict channel
interface ipff_out_if;
  logic                 valid;
  logic                 ready;
  logic                 drop_frame;
  ipff_pkg::cause_t     cause;

  modport source (output valid, output drop_frame, output cause, input ready);
  modport sink   (input valid, input drop_frame, input cause, output ready);
endinterface

/* src/ipv4_five_tuple_packet_filter_top.sv */
// the verdict for a frame is registered in the result register when its last byte leaves the input register
// throughput: one frame byte per cycle, set by the single capture/compare stage
// a stalled verdict holds the next last byte in the input register; other bytes flow on
// reset (rst_n low, synchronous): frame state cleared, match_protocol = 1, others 0
module ipv4_five_tuple_packet_filter_top (
  input  logic              clk,
  input  logic              rst_n,
  ipff_in_if.sink           in_if,
  ipff_out_if.source        out_if,
  input  logic              cfg_we,
  input  logic [2:0]        cfg_index,
  input  logic [31:0]       cfg_wdata
);

  // configuration registers
  logic [31:0] match_src_addr_r;
  logic [31:0] match_dst_addr_r;
  logic [7:0]  match_proto_r;
  logic [15:0] match_src_port_r;
  logic [15:0] match_dst_port_r;

  // input register
  logic       s1_valid_r;
  logic [7:0] s1_byte_r;
  logic       s1_last_r;

  // frame state
  logic [5:0]  pos_r;
  logic [15:0] etype_r;
  logic [7:0]  proto_r;
  logic [31:0] src_addr_r;
  logic [31:0] dst_addr_r;
  logic [15:0] src_port_r;
  logic [15:0] dst_port_r;

  // captured values including the current byte
  logic [15:0] etype_nxt;
  logic [7:0]  proto_nxt;
  logic [31:0] src_addr_nxt;
  logic [31:0] dst_addr_nxt;
  logic [15:0] src_port_nxt;
  logic [15:0] dst_port_nxt;
  logic [5:0]  len;

  // result register
  logic              out_valid_r;
  logic              out_drop_r;
  ipff_pkg::cause_t  out_cause_r;
  ipff_pkg::cause_t  cause_w;

  logic s1_fire;
  logic in_fire;

  // a non-last word never waits; a last word needs the result slot
  assign s1_fire = s1_valid_r && (!s1_last_r || !out_valid_r || out_if.ready);
  assign in_if.ready = !s1_valid_r || s1_fire;
  assign in_fire = in_if.valid && in_if.ready;

  assign out_if.valid      = out_valid_r;
  assign out_if.drop_frame = out_drop_r;
  assign out_if.cause      = out_cause_r;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      match_src_addr_r <= '0;
      match_dst_addr_r <= '0;
      match_proto_r    <= ipff_pkg::PROTO_ICMP;
      match_src_port_r <= '0;
      match_dst_port_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        ipff_pkg::CFG_SRC_ADDR: match_src_addr_r <= cfg_wdata;
        ipff_pkg::CFG_DST_ADDR: match_dst_addr_r <= cfg_wdata;
        ipff_pkg::CFG_PROTO:    match_proto_r    <= cfg_wdata[7:0];
        ipff_pkg::CFG_SRC_PORT: match_src_port_r <= cfg_wdata[15:0];
        ipff_pkg::CFG_DST_PORT: match_dst_port_r <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_fire) begin
      s1_valid_r <= 1'b1;
    end else if (s1_fire) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_byte_r <= in_if.frame_byte;
      s1_last_r <= in_if.frame_last;
    end
  end

  // byte capture by position
  always_comb begin
    etype_nxt    = etype_r;
    proto_nxt    = proto_r;
    src_addr_nxt = src_addr_r;
    dst_addr_nxt = dst_addr_r;
    src_port_nxt = src_port_r;
    dst_port_nxt = dst_port_r;
    // ethertype at 12-13, protocol at 23, addresses at 26-33, ports at 34-37
    priority if (pos_r == 6'd12 || pos_r == 6'd13) begin
      etype_nxt = {etype_r[7:0], s1_byte_r};
    end else if (pos_r == 6'd23) begin
      proto_nxt = s1_byte_r;
    end else if (pos_r >= 6'd26 && pos_r <= 6'd29) begin
      src_addr_nxt = {src_addr_r[23:0], s1_byte_r};
    end else if (pos_r >= 6'd30 && pos_r <= 6'd33) begin
      dst_addr_nxt = {dst_addr_r[23:0], s1_byte_r};
    end else if (pos_r == 6'd34 || pos_r == 6'd35) begin
      src_port_nxt = {src_port_r[7:0], s1_byte_r};
    end else if (pos_r == 6'd36 || pos_r == 6'd37) begin
      dst_port_nxt = {dst_port_r[7:0], s1_byte_r};
    end else begin
      etype_nxt = etype_r;
    end
  end

  // verdict for a frame ending on this byte
  assign len = pos_r + 6'd1;

  always_comb begin
    priority if (len < ipff_pkg::LEN_ETH_HDR) begin
      cause_w = ipff_pkg::CAUSE_SHORT;
    end else if (etype_nxt == ipff_pkg::ETYPE_ARP || etype_nxt == ipff_pkg::ETYPE_RARP) begin
      cause_w = ipff_pkg::CAUSE_NON_IP;
    end else if (etype_nxt != ipff_pkg::ETYPE_IPV4) begin
      cause_w = ipff_pkg::CAUSE_NON_IP;
    end else if (len < ipff_pkg::LEN_IP_HDR) begin
      cause_w = ipff_pkg::CAUSE_SHORT;
    end else if (match_src_addr_r != '0 && src_addr_nxt != match_src_addr_r) begin
      cause_w = ipff_pkg::CAUSE_MISMATCH;
    end else if (match_dst_addr_r != '0 && dst_addr_nxt != match_dst_addr_r) begin
      cause_w = ipff_pkg::CAUSE_MISMATCH;
    end else if (proto_nxt != match_proto_r) begin
      cause_w = ipff_pkg::CAUSE_PROTO;
    end else if (proto_nxt == ipff_pkg::PROTO_UDP && len < ipff_pkg::LEN_UDP_HDR) begin
      cause_w = ipff_pkg::CAUSE_SHORT;
    end else if (proto_nxt == ipff_pkg::PROTO_TCP && len < ipff_pkg::LEN_TCP_HDR) begin
      cause_w = ipff_pkg::CAUSE_SHORT;
    end else if (proto_nxt != ipff_pkg::PROTO_UDP && proto_nxt != ipff_pkg::PROTO_TCP) begin
      cause_w = ipff_pkg::CAUSE_UNSUP;
    end else if (match_src_port_r != '0 && src_port_nxt != match_src_port_r) begin
      cause_w = ipff_pkg::CAUSE_MISMATCH;
    end else if (match_dst_port_r != '0 && dst_port_nxt != match_dst_port_r) begin
      cause_w = ipff_pkg::CAUSE_MISMATCH;
    end else begin
      cause_w = ipff_pkg::CAUSE_MATCH;
    end
  end

  // frame state update, cleared after the last byte
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r      <= '0;
      etype_r    <= '0;
      proto_r    <= '0;
      src_addr_r <= '0;
      dst_addr_r <= '0;
      src_port_r <= '0;
      dst_port_r <= '0;
    end else if (s1_fire) begin
      if (s1_last_r) begin
        pos_r      <= '0;
        etype_r    <= '0;
        proto_r    <= '0;
        src_addr_r <= '0;
        dst_addr_r <= '0;
        src_port_r <= '0;
        dst_port_r <= '0;
      end else begin
        pos_r      <= (pos_r < ipff_pkg::POS_LIMIT) ? len : pos_r;
        etype_r    <= etype_nxt;
        proto_r    <= proto_nxt;
        src_addr_r <= src_addr_nxt;
        dst_addr_r <= dst_addr_nxt;
        src_port_r <= src_port_nxt;
        dst_port_r <= dst_port_nxt;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_fire && s1_last_r) begin
      out_valid_r <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && s1_last_r) begin
      out_drop_r  <= (cause_w == ipff_pkg::CAUSE_MATCH) ? ipff_pkg::VERDICT_DROP
                                                        : ipff_pkg::VERDICT_PASS;
      out_cause_r <= cause_w;
    end
  end

`ifndef ASSERT_OFF
  // byte position never runs past its limit
  a_pos_limit: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= ipff_pkg::POS_LIMIT)
    else $error("byte position past limit");

  // a finished frame leaves the position at zero
  a_pos_clear: assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire && s1_last_r |=> pos_r == '0)
    else $error("frame state not cleared after last byte");

  // a held input word keeps its contents
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !s1_fire |=> s1_valid_r && $stable(s1_byte_r) && $stable(s1_last_r))
    else $error("stalled input word changed");

  // drop only on a full tuple match
  a_drop_cause: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_drop_r == (out_cause_r == ipff_pkg::CAUSE_MATCH)))
    else $error("drop and cause disagree");
`endif

endmodule
